// ===== sv/pott_pkg.sv =====
// Package for the priority ordered task table: field widths, operation and
// status codes, and the result type of the shared compare unit.
// No dependencies.
`default_nettype none

package pott_pkg;

   localparam int SLOT_COUNT_DEF = 16;

   localparam int OP_W      = 3;
   localparam int PRIO_W    = 8;
   localparam int SID_W     = 4;
   localparam int TAG_W     = 32;
   localparam int STAT_W    = 2;
   localparam int CNT_OUT_W = 5;

   // longest run order answer, and the ceiling of the reported count
   localparam int RUN_MAX = 16;
   localparam int CNT_SAT = 31;

   localparam logic [PRIO_W-1:0] PRIO_RESET = 8'hFF;

   localparam logic [OP_W-1:0] OP_RESET   = 3'd0;
   localparam logic [OP_W-1:0] OP_CREATE  = 3'd1;
   localparam logic [OP_W-1:0] OP_DESTROY = 3'd2;
   localparam logic [OP_W-1:0] OP_RUN     = 3'd3;
   localparam logic [OP_W-1:0] OP_FIND    = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_MISS  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_res_type;

endpackage

`default_nettype wire

// ===== sv/pott_if.sv =====
// Handshake channels of the task table: request channel and response channel.
// Depends on pott_pkg for the payload widths.
`default_nettype none

interface pott_req_if;
   logic                          valid;
   logic                          ready;
   logic [pott_pkg::OP_W-1:0]     op;
   logic [pott_pkg::PRIO_W-1:0]   prio;
   logic [pott_pkg::SID_W-1:0]    slot_id;
   logic [pott_pkg::TAG_W-1:0]    func_tag;

   modport source (output valid, op, prio, slot_id, func_tag, input ready);
   modport sink   (input valid, op, prio, slot_id, func_tag, output ready);
endinterface

interface pott_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [pott_pkg::SID_W-1:0]       slot_out;
   logic [pott_pkg::STAT_W-1:0]      status;
   logic [pott_pkg::CNT_OUT_W-1:0]   active_count;
   logic                             last;

   modport source (output valid, slot_out, status, active_count, last, input ready);
   modport sink   (input valid, slot_out, status, active_count, last, output ready);
endinterface

`default_nettype wire

// ===== sv/pott_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Depends on pott_pkg for default sizes.
`default_nettype none

module pott_ram #(
   parameter int WIDTH = pott_pkg::PRIO_W,
   parameter int DEPTH = pott_pkg::SLOT_COUNT_DEF,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== sv/pott_cmp.sv =====
// Shared compare unit of the task table: less-than and equality on one operand pair.
// Depends on pott_pkg for the operand width and result type.
`default_nettype none

module pott_cmp (
   input  wire logic [pott_pkg::TAG_W-1:0] a,
   input  wire logic [pott_pkg::TAG_W-1:0] b,
   output pott_pkg::cmp_res_type           res
);

   assign res.lt = (a < b);
   assign res.eq = (a == b);

endmodule

`default_nettype wire

// ===== sv/priority_ordered_task_table.sv =====
// Priority ordered task table. SLOT_COUNT task slots form a doubly linked list
// sorted by priority number, lowest first, ties in creation order. One request
// item runs one operation (reset all, create, destroy, run order, find by tag)
// and the block takes no new item until its last response has been taken.
// Each step reads one slot through the single read port of the slot RAMs and
// the shared comparator, a read state and then a check state per slot: destroy
// reads the slot and then writes the neighbour links (an inactive slot answers
// a miss straight from idle), find scans the slots by tag, create searches for
// a free slot, then scans the slots for the list head, walks the entries and
// links in ST_LINK_A and ST_LINK_B; run order scans for the head and then reads
// each listed task, waiting on each response. Reset all and unknown operations
// answer straight from idle. No clearing pass after reset.
// Depends on pott_pkg, pott_if, pott_ram and pott_cmp.
`default_nettype none

module priority_ordered_task_table #(
   parameter int SLOT_COUNT = pott_pkg::SLOT_COUNT_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   pott_req_if.sink    req_if,
   pott_rsp_if.source  rsp_if
);

   localparam int IDX_W    = $clog2(SLOT_COUNT);
   localparam int LINK_W   = IDX_W + 1;
   localparam int CNT_W    = $clog2(SLOT_COUNT + 1);
   localparam int SO_W     = pott_pkg::SID_W;
   localparam int CO_W     = pott_pkg::CNT_OUT_W;
   localparam int TW       = pott_pkg::TAG_W;
   localparam int PW       = pott_pkg::PRIO_W;
   localparam int RUN_LEN  = (pott_pkg::RUN_MAX < SLOT_COUNT) ? pott_pkg::RUN_MAX : SLOT_COUNT;
   localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(SLOT_COUNT - 1);
   localparam logic [IDX_W-1:0]  RUN_LAST = IDX_W'(RUN_LEN - 1);
   localparam logic [LINK_W-1:0] LINK_END = '1;

   typedef enum logic [14:0] {
      ST_IDLE    = 15'h0001,
      ST_FREE    = 15'h0002,
      ST_HEAD_RD = 15'h0004,
      ST_HEAD_CK = 15'h0008,
      ST_WALK_RD = 15'h0010,
      ST_WALK_CK = 15'h0020,
      ST_LINK_A  = 15'h0040,
      ST_LINK_B  = 15'h0080,
      ST_DEL_RD  = 15'h0100,
      ST_DEL_WR  = 15'h0200,
      ST_RUN_RD  = 15'h0400,
      ST_RUN_CK  = 15'h0800,
      ST_TAG_RD  = 15'h1000,
      ST_TAG_CK  = 15'h2000,
      ST_RESP    = 15'h4000
   } state_type;

   typedef enum logic [2:0] {
      LNK_BEFORE = 3'b001,
      LNK_TAIL   = 3'b010,
      LNK_ALONE  = 3'b100
   } link_mode_type;

   typedef struct packed {
      logic prio;
      logic func;
      logic prev;
      logic next;
   } rd_vld_type;

   function automatic logic link_ok(input logic [LINK_W-1:0] l);
      return l < LINK_W'(SLOT_COUNT);
   endfunction

   // control state
   state_type               state_ff, state_in;
   logic [SLOT_COUNT-1:0]   act_ff, act_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [SLOT_COUNT-1:0]   vld_prio_ff, vld_prio_in;
   logic [SLOT_COUNT-1:0]   vld_func_ff, vld_func_in;
   logic [SLOT_COUNT-1:0]   vld_prev_ff, vld_prev_in;
   logic [SLOT_COUNT-1:0]   vld_next_ff, vld_next_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // item and walk registers
   logic [pott_pkg::OP_W-1:0] op_ff, op_in;
   logic [PW-1:0]             prio_ff, prio_in;
   logic [SO_W-1:0]           sid_ff, sid_in;
   logic [TW-1:0]             tag_ff, tag_in;
   logic [IDX_W-1:0]          scan_ff, scan_in;
   logic [IDX_W-1:0]          cur_ff, cur_in;
   logic [IDX_W-1:0]          step_ff, step_in;
   logic [IDX_W-1:0]          new_ff, new_in;
   logic [LINK_W-1:0]         plink_ff, plink_in;
   link_mode_type             mode_ff, mode_in;
   logic [SO_W-1:0]           rsp_slot_ff, rsp_slot_in;
   logic [pott_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CO_W-1:0]           rsp_count_ff, rsp_count_in;
   logic                      rsp_last_ff, rsp_last_in;

   // read side
   logic [IDX_W-1:0]  rd_addr;
   logic [IDX_W-1:0]  rd_idx_ff;
   rd_vld_type        rd_vld_ff;
   logic [PW-1:0]     prio_rd, prio_rv;
   logic [TW-1:0]     func_rd, func_rv;
   logic [LINK_W-1:0] prev_rd, prev_rv;
   logic [LINK_W-1:0] next_rd, next_rv;

   // write side
   logic              prio_we, func_we, prev_we, next_we;
   logic [IDX_W-1:0]  prio_wa, func_wa, prev_wa, next_wa;
   logic [LINK_W-1:0] prev_wd, next_wd;

   logic [TW-1:0]          cmp_a, cmp_b;
   pott_pkg::cmp_res_type  cmp_res;

   pott_ram #(.WIDTH(PW), .DEPTH(SLOT_COUNT)) u_prio_ram (
      .clock(clock), .wr_en(prio_we), .wr_addr(prio_wa), .wr_data(prio_ff),
      .rd_addr(rd_addr), .rd_data(prio_rd)
   );

   pott_ram #(.WIDTH(TW), .DEPTH(SLOT_COUNT)) u_func_ram (
      .clock(clock), .wr_en(func_we), .wr_addr(func_wa), .wr_data(tag_ff),
      .rd_addr(rd_addr), .rd_data(func_rd)
   );

   pott_ram #(.WIDTH(LINK_W), .DEPTH(SLOT_COUNT)) u_prev_ram (
      .clock(clock), .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
      .rd_addr(rd_addr), .rd_data(prev_rd)
   );

   pott_ram #(.WIDTH(LINK_W), .DEPTH(SLOT_COUNT)) u_next_ram (
      .clock(clock), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr(rd_addr), .rd_data(next_rd)
   );

   pott_cmp u_cmp (.a(cmp_a), .b(cmp_b), .res(cmp_res));

   // entries never written read as their reset values
   always_comb begin
      prio_rv = rd_vld_ff.prio ? prio_rd : pott_pkg::PRIO_RESET;
      func_rv = rd_vld_ff.func ? func_rd : '0;
      if (rd_vld_ff.prev) begin
         prev_rv = prev_rd;
      end else begin
         prev_rv = (rd_idx_ff == '0) ? LINK_END : LINK_W'(rd_idx_ff);
      end
      if (rd_vld_ff.next) begin
         next_rv = next_rd;
      end else begin
         next_rv = (rd_idx_ff == IDX_LAST) ? LINK_END : LINK_W'(rd_idx_ff) + LINK_W'(1);
      end
   end

   always_comb begin
      case (state_ff)
         ST_WALK_RD, ST_RUN_RD: rd_addr = cur_ff;
         ST_DEL_RD:             rd_addr = IDX_W'(sid_ff);
         default:               rd_addr = scan_ff;
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_WALK_CK: begin
            cmp_a = TW'(prio_ff);
            cmp_b = TW'(prio_rv);
         end
         ST_HEAD_CK: begin
            cmp_a = TW'(prev_rv);
            cmp_b = TW'(LINK_END);
         end
         default: begin
            cmp_a = tag_ff;
            cmp_b = func_rv;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      op_in         = op_ff;
      prio_in       = prio_ff;
      sid_in        = sid_ff;
      tag_in        = tag_ff;
      scan_in       = scan_ff;
      cur_in        = cur_ff;
      step_in       = step_ff;
      new_in        = new_ff;
      plink_in      = plink_ff;
      mode_in       = mode_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      prio_we = 1'b0;
      func_we = 1'b0;
      prev_we = 1'b0;
      next_we = 1'b0;
      prio_wa = new_ff;
      func_wa = new_ff;
      prev_wa = new_ff;
      next_wa = new_ff;
      prev_wd = LINK_END;
      next_wd = LINK_END;
      vld_prio_in = vld_prio_ff;
      vld_func_in = vld_func_ff;
      vld_prev_in = vld_prev_ff;
      vld_next_in = vld_next_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               op_in   = req_if.op;
               prio_in = req_if.prio;
               sid_in  = req_if.slot_id;
               tag_in  = req_if.func_tag;
               scan_in = '0;
               case (req_if.op)
                  pott_pkg::OP_RESET: begin
                     act_in      = '0;
                     cnt_in      = '0;
                     vld_prio_in = '0;
                     vld_func_in = '0;
                     vld_prev_in = '0;
                     vld_next_in = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_slot_in   = '0;
                     rsp_status_in = pott_pkg::STAT_OK;
                     rsp_last_in   = 1'b1;
                     state_in      = ST_RESP;
                  end
                  pott_pkg::OP_CREATE: state_in = ST_FREE;
                  pott_pkg::OP_DESTROY: begin
                     if ((32'(req_if.slot_id) < 32'(SLOT_COUNT))
                         && act_ff[IDX_W'(req_if.slot_id)]) begin
                        state_in = ST_DEL_RD;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_slot_in   = '0;
                        rsp_status_in = pott_pkg::STAT_MISS;
                        rsp_last_in   = 1'b1;
                        state_in      = ST_RESP;
                     end
                  end
                  pott_pkg::OP_RUN:  state_in = ST_HEAD_RD;
                  pott_pkg::OP_FIND: state_in = ST_TAG_RD;
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_slot_in   = '0;
                     rsp_status_in = pott_pkg::STAT_OK;
                     rsp_last_in   = 1'b1;
                     state_in      = ST_RESP;
                  end
               endcase
            end
         end

         ST_FREE: begin
            if (!act_ff[scan_ff]) begin
               new_in  = scan_ff;
               prio_we = 1'b1;
               prio_wa = scan_ff;
               func_we = 1'b1;
               func_wa = scan_ff;
               vld_prio_in[scan_ff] = 1'b1;
               vld_func_in[scan_ff] = 1'b1;
               scan_in  = '0;
               state_in = ST_HEAD_RD;
            end else if (scan_ff == IDX_LAST) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = '0;
               rsp_status_in = pott_pkg::STAT_FULL;
               rsp_last_in   = 1'b1;
               state_in      = ST_RESP;
            end else begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end

         ST_HEAD_RD: state_in = ST_HEAD_CK;

         ST_HEAD_CK: begin
            if (act_ff[scan_ff] && cmp_res.eq) begin
               cur_in   = scan_ff;
               step_in  = '0;
               state_in = (op_ff == pott_pkg::OP_CREATE) ? ST_WALK_RD : ST_RUN_RD;
            end else if (scan_ff == IDX_LAST) begin
               if (op_ff == pott_pkg::OP_CREATE) begin
                  mode_in  = LNK_ALONE;
                  state_in = ST_LINK_A;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_slot_in   = '0;
                  rsp_status_in = pott_pkg::STAT_EMPTY;
                  rsp_last_in   = 1'b1;
                  state_in      = ST_RESP;
               end
            end else begin
               scan_in  = scan_ff + IDX_W'(1);
               state_in = ST_HEAD_RD;
            end
         end

         ST_WALK_RD: state_in = ST_WALK_CK;

         ST_WALK_CK: begin
            if (cmp_res.lt) begin
               plink_in = prev_rv;
               mode_in  = LNK_BEFORE;
               state_in = ST_LINK_A;
            end else if (!link_ok(next_rv)) begin
               mode_in  = LNK_TAIL;
               state_in = ST_LINK_A;
            end else begin
               cur_in = IDX_W'(next_rv);
               if (step_ff == IDX_LAST) begin
                  // walk bound hit: append after the slot reached
                  mode_in  = LNK_TAIL;
                  state_in = ST_LINK_A;
               end else begin
                  step_in  = step_ff + IDX_W'(1);
                  state_in = ST_WALK_RD;
               end
            end
         end

         ST_LINK_A: begin
            prev_we = 1'b1;
            next_we = 1'b1;
            vld_prev_in[new_ff] = 1'b1;
            vld_next_in[new_ff] = 1'b1;
            case (mode_ff)
               LNK_BEFORE: begin
                  prev_wd = plink_ff;
                  next_wd = LINK_W'(cur_ff);
               end
               LNK_TAIL: begin
                  prev_wd = LINK_W'(cur_ff);
                  next_wd = LINK_END;
               end
               default: begin
                  prev_wd = LINK_END;
                  next_wd = LINK_END;
               end
            endcase
            state_in = ST_LINK_B;
         end

         ST_LINK_B: begin
            case (mode_ff)
               LNK_BEFORE: begin
                  prev_we = 1'b1;
                  prev_wa = cur_ff;
                  prev_wd = LINK_W'(new_ff);
                  vld_prev_in[cur_ff] = 1'b1;
                  if (link_ok(plink_ff)) begin
                     next_we = 1'b1;
                     next_wa = IDX_W'(plink_ff);
                     next_wd = LINK_W'(new_ff);
                     vld_next_in[IDX_W'(plink_ff)] = 1'b1;
                  end
               end
               LNK_TAIL: begin
                  next_we = 1'b1;
                  next_wa = cur_ff;
                  next_wd = LINK_W'(new_ff);
                  vld_next_in[cur_ff] = 1'b1;
               end
               default: ;
            endcase
            act_in[new_ff] = 1'b1;
            cnt_in        = cnt_ff + CNT_W'(1);
            rsp_valid_in  = 1'b1;
            rsp_slot_in   = SO_W'(new_ff);
            rsp_status_in = pott_pkg::STAT_OK;
            rsp_last_in   = 1'b1;
            state_in      = ST_RESP;
         end

         ST_DEL_RD: state_in = ST_DEL_WR;

         ST_DEL_WR: begin
            if (link_ok(prev_rv)) begin
               next_we = 1'b1;
               next_wa = IDX_W'(prev_rv);
               next_wd = next_rv;
               vld_next_in[IDX_W'(prev_rv)] = 1'b1;
            end
            if (link_ok(next_rv)) begin
               prev_we = 1'b1;
               prev_wa = IDX_W'(next_rv);
               prev_wd = prev_rv;
               vld_prev_in[IDX_W'(next_rv)] = 1'b1;
            end
            act_in[IDX_W'(sid_ff)] = 1'b0;
            cnt_in        = cnt_ff - CNT_W'(1);
            rsp_valid_in  = 1'b1;
            rsp_slot_in   = sid_ff;
            rsp_status_in = pott_pkg::STAT_OK;
            rsp_last_in   = 1'b1;
            state_in      = ST_RESP;
         end

         ST_RUN_RD: state_in = ST_RUN_CK;

         ST_RUN_CK: begin
            rsp_valid_in  = 1'b1;
            rsp_slot_in   = SO_W'(cur_ff);
            rsp_status_in = pott_pkg::STAT_OK;
            rsp_last_in   = !link_ok(next_rv) || (step_ff == RUN_LAST);
            cur_in        = IDX_W'(next_rv);
            state_in      = ST_RESP;
         end

         ST_TAG_RD: state_in = ST_TAG_CK;

         ST_TAG_CK: begin
            if (act_ff[scan_ff] && cmp_res.eq) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = SO_W'(scan_ff);
               rsp_status_in = pott_pkg::STAT_OK;
               rsp_last_in   = 1'b1;
               state_in      = ST_RESP;
            end else if (scan_ff == IDX_LAST) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = '0;
               rsp_status_in = pott_pkg::STAT_MISS;
               rsp_last_in   = 1'b1;
               state_in      = ST_RESP;
            end else begin
               scan_in  = scan_ff + IDX_W'(1);
               state_in = ST_TAG_RD;
            end
         end

         ST_RESP: begin
            if (rsp_if.ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  step_in  = step_ff + IDX_W'(1);
                  state_in = ST_RUN_RD;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // count reported with each item is the one left after the operation
      if (state_ff != ST_RESP && rsp_valid_in) begin
         rsp_count_in = (32'(cnt_in) > 32'(pott_pkg::CNT_SAT))
                        ? CO_W'(pott_pkg::CNT_SAT) : CO_W'(cnt_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         act_ff       <= '0;
         cnt_ff       <= '0;
         vld_prio_ff  <= '0;
         vld_func_ff  <= '0;
         vld_prev_ff  <= '0;
         vld_next_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         act_ff       <= act_in;
         cnt_ff       <= cnt_in;
         vld_prio_ff  <= vld_prio_in;
         vld_func_ff  <= vld_func_in;
         vld_prev_ff  <= vld_prev_in;
         vld_next_ff  <= vld_next_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      prio_ff       <= prio_in;
      sid_ff        <= sid_in;
      tag_ff        <= tag_in;
      scan_ff       <= scan_in;
      cur_ff        <= cur_in;
      step_ff       <= step_in;
      new_ff        <= new_in;
      plink_ff      <= plink_in;
      mode_ff       <= mode_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
      rd_idx_ff     <= rd_addr;
      rd_vld_ff     <= '{prio: vld_prio_ff[rd_addr], func: vld_func_ff[rd_addr],
                         prev: vld_prev_ff[rd_addr], next: vld_next_ff[rd_addr]};
   end

   assign req_if.ready        = (state_ff == ST_IDLE);
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.slot_out     = rsp_slot_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.active_count = rsp_count_ff;
   assign rsp_if.last         = rsp_last_ff;

   a_no_accept_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !req_if.ready)
      else $error("request ready while a response item is pending");

   a_count_matches_flags: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) == $countones(act_ff))
      else $error("active count out of step with active flags");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> (state_ff != ST_IDLE))
      else $error("accepted item did not start an operation");

endmodule

`default_nettype wire
